// ===== rtl/adcm3s_pkg.sv =====
// Shared types, constants and the median-of-three function for the ADC sequencer.
package adcm3s_pkg;

  localparam int REQ_W       = 4;
  localparam int CHAN_W      = 3;
  localparam int SAMPLE_W    = 12;
  localparam int ROUND_W     = 2;
  localparam int POS_W       = 3;
  localparam int QUEUE_DEPTH = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALTERNATE = 4'd9;

  // Channel that ends a full round
  localparam logic [CHAN_W-1:0] CHAN_ROUND_END = 3'd5;

  // Position sequence codes
  localparam logic [POS_W-1:0] POS_SKIP     = 3'd3;
  localparam logic [POS_W-1:0] POS_SKIP_TO  = 3'd4;
  localparam logic [POS_W-1:0] POS_WRAP_MIN = 3'd6;

  localparam logic [ROUND_W-1:0] ROUND_FULL = 2'd2;

  // Classified beat handed from the front end to the back end
  typedef struct packed {
    logic                bad;
    logic                full;
    logic [1:0]          slot;
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] sample;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic                median_valid;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] median;
    logic                bad_channel;
  } res_t;

  function automatic logic [SAMPLE_W-1:0] med3(input logic [SAMPLE_W-1:0] a,
                                               input logic [SAMPLE_W-1:0] b,
                                               input logic [SAMPLE_W-1:0] c);
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

endpackage

// ===== rtl/adcm3s_fifo.sv =====
// Small first-in first-out queue with flop storage and a count.
module adcm3s_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count above depth");
`endif

endmodule

// ===== rtl/adcm3s_front.sv =====
// Front end: resolve the requested channel, classify the beat, step position and round.
module adcm3s_front #(
  parameter int CHANNELS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [adcm3s_pkg::REQ_W-1:0] request_channel,
  input  logic [adcm3s_pkg::SAMPLE_W-1:0] sample,
  input  logic                         cmd_full,
  output logic                         cmd_push,
  output adcm3s_pkg::cmd_t             cmd
);

  import adcm3s_pkg::*;

  logic [POS_W-1:0]   position_r, position_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic               toggle_r, toggle_nxt;
  logic [POS_W-1:0]   pos_inc;
  logic [REQ_W-1:0]   chan_res;
  logic               accept, is_alt, bad, full_round;

  assign accept     = push && !cmd_full;
  assign is_alt     = (request_channel == REQ_ALTERNATE);
  assign chan_res   = is_alt ? {3'b011, toggle_r} : request_channel;
  assign bad        = (chan_res >= REQ_W'(CHANNELS));
  assign full_round = (round_r >= ROUND_FULL);
  assign pos_inc    = position_r + 1'b1;

  always_comb begin
    cmd.bad    = bad;
    cmd.full   = full_round && !bad;
    cmd.slot   = (round_r > ROUND_FULL) ? ROUND_FULL : round_r;
    cmd.chan   = bad ? '0 : chan_res[CHAN_W-1:0];
    cmd.sample = sample;
  end

  assign cmd_push = accept;

  always_comb begin
    position_nxt = position_r;
    round_nxt    = round_r;
    toggle_nxt   = toggle_r;
    if (accept) begin
      if (is_alt) begin
        toggle_nxt = !toggle_r;
      end
      if (!bad) begin
        // Advance 0,1,2,4,5 and wrap; each wrap bumps the saturating round
        position_nxt = (pos_inc == POS_SKIP) ? POS_SKIP_TO : pos_inc;
        if (pos_inc >= POS_WRAP_MIN || pos_inc == '0) begin
          position_nxt = '0;
          if (round_r < ROUND_FULL) begin
            round_nxt = round_r + 1'b1;
          end
        end
        if (full_round && chan_res[CHAN_W-1:0] == CHAN_ROUND_END) begin
          round_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      round_r    <= '0;
      toggle_r   <= 1'b0;
    end else begin
      position_r <= position_nxt;
      round_r    <= round_nxt;
      toggle_r   <= toggle_nxt;
    end
  end

`ifndef SYNTHESIS
  a_round_sat: assert property (@(posedge clk) disable iff (!rst_n)
    round_r != 2'd3)
    else $error("round above saturation");

  a_pos_legal: assert property (@(posedge clk) disable iff (!rst_n)
    position_r != POS_SKIP && position_r < POS_WRAP_MIN)
    else $error("position left its sequence");

  a_toggle_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_alt) |=> (toggle_r != $past(toggle_r)))
    else $error("alternate request did not flip channel toggle");
`endif

endmodule

// ===== rtl/adcm3s_back.sv =====
// Back end: per-channel three-slot store, sample write and median of three.
module adcm3s_back #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  adcm3s_pkg::cmd_t cmd,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output adcm3s_pkg::res_t res
);

  import adcm3s_pkg::*;

  localparam int SB = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

  logic [SB-1:0] store_r [CHANNELS][3];
  logic [SB-1:0] row [3];
  logic [SB-1:0] smp;
  logic          proc;

  assign proc     = cmd_valid && !res_full;
  assign cmd_pop  = proc;
  assign res_push = proc;
  assign smp      = cmd.sample[SB-1:0];

  // Row of the channel with the new sample in place
  always_comb begin
    for (int s = 0; s < 3; s++) begin
      row[s] = store_r[cmd.chan][s];
      if (cmd.slot == 2'(s)) begin
        row[s] = smp;
      end
    end
  end

  always_comb begin
    res.bad_channel  = cmd.bad;
    res.median_valid = cmd.full;
    res.channel      = cmd.chan;
    res.median       = '0;
    if (cmd.full) begin
      res.median = med3(SAMPLE_W'(row[0]), SAMPLE_W'(row[1]), SAMPLE_W'(row[2]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int s = 0; s < 3; s++) begin
          store_r[c][s] <= '0;
        end
      end
    end else if (proc && !cmd.bad) begin
      for (int s = 0; s < 3; s++) begin
        store_r[cmd.chan][s] <= row[s];
      end
    end
  end

`ifndef SYNTHESIS
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && cmd.bad) |-> (!res.median_valid && res.channel == '0 && res.median == '0))
    else $error("rejected beat carries channel or median");
`endif

endmodule

// ===== rtl/adc_median_of_three_sequencer_top.sv =====
// Top level of the ADC median-of-three sequencer: front end, both queues, back end.
// A beat is written into the command queue; the back end writes its result into the result queue, which lowers empty.
// Throughput: one beat per cycle sustained while no queue is full; the front end and the back end
//   each take one beat per cycle unless their queue is full, and two-entry queues decouple them and the result side.
// Reset: synchronous active-low rst_n clears position, round, the channel toggle,
//   the sample store and both queues; no clearing pass is needed.
module adc_median_of_three_sequencer_top #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input queue side
  input  logic                            push,
  output logic                            full,
  input  logic [adcm3s_pkg::REQ_W-1:0]    in_request_channel,
  input  logic [adcm3s_pkg::SAMPLE_W-1:0] in_sample,
  // Result queue side
  output logic                            empty,
  input  logic                            pop,
  output logic                            out_median_valid,
  output logic [adcm3s_pkg::CHAN_W-1:0]   out_channel,
  output logic [adcm3s_pkg::SAMPLE_W-1:0] out_median,
  output logic                            out_bad_channel
);

  import adcm3s_pkg::*;

  cmd_t front_cmd, back_cmd;
  res_t back_res, out_res;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic res_push, res_full;

  // Classify each beat and step the sequence counters in order of arrival
  adcm3s_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .request_channel (in_request_channel),
    .sample          (in_sample),
    .cmd_full        (cmd_full),
    .cmd_push        (cmd_push),
    .cmd             (front_cmd)
  );

  assign full = cmd_full;

  // Hold classified beats until the back end takes them
  adcm3s_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (front_cmd),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (back_cmd),
    .empty   (cmd_empty)
  );

  // Store the sample and compute the median when the round is full
  adcm3s_back #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  // Park finished results so the back end keeps moving while the consumer stalls, until the queue is full
  adcm3s_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (back_res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (out_res),
    .empty   (empty)
  );

  assign out_median_valid = out_res.median_valid;
  assign out_channel      = out_res.channel;
  assign out_median       = out_res.median;
  assign out_bad_channel  = out_res.bad_channel;

endmodule

// ===== dv/testbench.sv =====
// Testbench for the ADC median-of-three sequencer: table-driven and random beats.
`timescale 1ns / 100ps

module testbench;
  import adcm3s_pkg::*;

  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 12;
  localparam int SLOTS       = 3;
  localparam int RANDOM_BEATS = 1950;
  localparam int DIR_ROWS    = 24;
  localparam int LIMIT       = 200000;
  localparam int TAIL_CYCLES = 8;

  // Request code that the block always rejects
  localparam logic [REQ_W-1:0] REQ_INVALID = 4'd8;

  // One stimulus row: the request, the sample and, where it is obvious, the result
  typedef struct packed {
    logic [REQ_W-1:0]    req;
    logic [SAMPLE_W-1:0] smp;
    logic                typed;
    res_t                want;
  } beat_t;

  localparam res_t RES_NONE      = '0;
  localparam res_t RES_REJECT    = '{1'b0, 3'd0, 12'd0, 1'b1};
  localparam res_t RES_CH0_EARLY = '{1'b0, 3'd0, 12'd0, 1'b0};
  localparam res_t RES_CH6_EARLY = '{1'b0, 3'd6, 12'd0, 1'b0};
  localparam res_t RES_CH7_EARLY = '{1'b0, 3'd7, 12'd0, 1'b0};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                pop = 1'b0;
  logic [REQ_W-1:0]    in_request_channel = '0;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                full;
  logic                empty;
  logic                out_median_valid;
  logic [CHAN_W-1:0]   out_channel;
  logic [SAMPLE_W-1:0] out_median;
  logic                out_bad_channel;

  // Model state: per-channel sample slots, position counter, round, 6/7 toggle
  logic [SAMPLE_W-1:0] sample_slots [CHANNELS][SLOTS];
  logic [POS_W-1:0]    seq_pos;
  logic [ROUND_W-1:0]  seq_round;
  logic                alt_to_seven;

  beat_t beats [$];
  res_t  median_results_q [$];
  res_t  model_out;
  res_t  want;
  int    send_idx = 0;
  int    phase = 0;
  int    err_count = 0;
  int    cycle_count = 0;

  // Directed part: extremes, the alternate request, rejects, round change,
  // medians with ties and the channel-5 round reset
  beat_t directed_tbl [DIR_ROWS] = '{
    '{4'd0,          12'hFFF, 1'b1, RES_CH0_EARLY},  // round 0, no median yet
    '{REQ_INVALID,   12'hFFF, 1'b1, RES_REJECT},
    '{4'd15,         12'h000, 1'b1, RES_REJECT},
    '{REQ_ALTERNATE, 12'h000, 1'b1, RES_CH6_EARLY},  // first alternate goes to 6
    '{REQ_ALTERNATE, 12'hFFF, 1'b1, RES_CH7_EARLY},
    '{REQ_ALTERNATE, 12'd100, 1'b0, RES_NONE},
    '{4'd10,         12'h000, 1'b1, RES_REJECT},     // toggle must not flip here
    '{4'd1,          12'h000, 1'b0, RES_NONE},       // fifth good beat: wraps to round 1
    '{4'd0,          12'h000, 1'b0, RES_NONE},
    '{4'd5,          12'd2048, 1'b0, RES_NONE},      // channel 5 before round 2
    '{4'd3,          12'd1,   1'b0, RES_NONE},
    '{REQ_ALTERNATE, 12'hFFF, 1'b0, RES_NONE},
    '{4'd7,          12'd7,   1'b0, RES_NONE},       // wraps to round 2 after this beat
    '{4'd0,          12'd2000, 1'b0, RES_NONE},      // median of 4095, 0, 2000
    '{4'd0,          12'hFFF, 1'b0, RES_NONE},       // tie at the top
    '{4'd6,          12'h000, 1'b0, RES_NONE},
    '{4'd5,          12'h000, 1'b0, RES_NONE},       // resets the round
    '{4'd4,          12'hFFF, 1'b0, RES_NONE},
    '{4'd11,         12'hFFF, 1'b1, RES_REJECT},
    '{4'd12,         12'h555, 1'b1, RES_REJECT},
    '{4'd13,         12'hAAA, 1'b1, RES_REJECT},
    '{4'd14,         12'h000, 1'b1, RES_REJECT},
    '{REQ_ALTERNATE, 12'hFFF, 1'b0, RES_NONE},
    '{4'd2,          12'h800, 1'b0, RES_NONE}
  };

  adc_median_of_three_sequencer_top #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_request_channel (in_request_channel),
    .in_sample          (in_sample),
    .empty              (empty),
    .pop                (pop),
    .out_median_valid   (out_median_valid),
    .out_channel        (out_channel),
    .out_median         (out_median),
    .out_bad_channel    (out_bad_channel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Idle percentage per side: sender light / receiver heavy, then swapped, then none
  function automatic int idle_pct(input int ph, input bit is_sender);
    case (ph)
      0:       return is_sender ? 16 : 69;
      1:       return is_sender ? 69 : 16;
      default: return 0;
    endcase
  endfunction

  // Run one accepted beat through the model: store, median, position and round
  function automatic res_t median_filter_step(input logic [REQ_W-1:0] req,
                                              input logic [SAMPLE_W-1:0] smp);
    res_t                r;
    logic [REQ_W-1:0]    ch;
    logic [1:0]          slot;
    logic                was_full;
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
    logic [SAMPLE_W-1:0] c;
    r  = '0;
    ch = req;
    if (req == REQ_ALTERNATE) begin
      ch = alt_to_seven ? 4'd7 : 4'd6;
      alt_to_seven = ~alt_to_seven;
    end
    // Rejects leave position, round and the store alone
    if (ch >= CHANNELS) begin
      r.bad_channel = 1'b1;
      return r;
    end
    slot     = (seq_round > ROUND_FULL) ? ROUND_FULL : seq_round;
    was_full = (seq_round >= ROUND_FULL);
    sample_slots[ch][slot] = smp;
    if (was_full) begin
      a = sample_slots[ch][0];
      b = sample_slots[ch][1];
      c = sample_slots[ch][2];
      if ((a >= b && a <= c) || (a <= b && a >= c))
        r.median = a;
      else if ((b >= a && b <= c) || (b <= a && b >= c))
        r.median = b;
      else
        r.median = c;
      r.median_valid = 1'b1;
    end
    r.channel = ch[CHAN_W-1:0];
    // Step 0,1,2,4,5 and wrap; each wrap advances the round up to its ceiling
    seq_pos = seq_pos + 1'b1;
    if (seq_pos == POS_SKIP)
      seq_pos = POS_SKIP_TO;
    if (seq_pos >= POS_WRAP_MIN || seq_pos == '0) begin
      seq_pos = '0;
      if (seq_round < ROUND_FULL)
        seq_round = seq_round + 1'b1;
    end
    if (was_full && ch[CHAN_W-1:0] == CHAN_ROUND_END)
      seq_round = '0;
    return r;
  endfunction

  // Sender: record the beat taken at this edge, then hold, present the next or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        model_out = median_filter_step(in_request_channel, in_sample);
        if (beats[send_idx].typed)
          median_results_q.push_back(beats[send_idx].want);
        else
          median_results_q.push_back(model_out);
        send_idx = send_idx + 1;
        phase <= (send_idx < beats.size() / 3) ? 0 :
                 (send_idx < 2 * beats.size() / 3) ? 1 : 2;
      end
      // Hold a refused beat as it is; otherwise pick the next one or idle
      if (!(push && full)) begin
        if (send_idx < beats.size() && $urandom_range(99) >= idle_pct(phase, 1'b1)) begin
          push               <= 1'b1;
          in_request_channel <= beats[send_idx].req;
          in_sample          <= beats[send_idx].smp;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: check the beat taken at this edge against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (median_results_q.size() == 0) begin
          $display("%0t: unexpected result: valid %0d channel %0d median %0d bad %0d",
                   $time, out_median_valid, out_channel, out_median, out_bad_channel);
          err_count = err_count + 1;
        end else begin
          want = median_results_q.pop_front();
          if (out_median_valid !== want.median_valid) begin
            $display("%0t: median_valid expected %0d actual %0d",
                     $time, want.median_valid, out_median_valid);
            err_count = err_count + 1;
          end
          if (out_channel !== want.channel) begin
            $display("%0t: channel expected %0d actual %0d", $time, want.channel, out_channel);
            err_count = err_count + 1;
          end
          if (out_median !== want.median) begin
            $display("%0t: median expected %0d actual %0d", $time, want.median, out_median);
            err_count = err_count + 1;
          end
          if (out_bad_channel !== want.bad_channel) begin
            $display("%0t: bad_channel expected %0d actual %0d",
                     $time, want.bad_channel, out_bad_channel);
            err_count = err_count + 1;
          end
        end
      end
      pop <= ($urandom_range(99) >= idle_pct(phase, 1'b0));
    end
  end

  initial begin
    logic [REQ_W-1:0]    req;
    logic [SAMPLE_W-1:0] smp;
    logic [SAMPLE_W-1:0] last_smp;
    int                  pick;
    beat_t               b;

    // Clear the model the way reset clears the block
    for (int ch = 0; ch < CHANNELS; ch++)
      for (int s = 0; s < SLOTS; s++)
        sample_slots[ch][s] = '0;
    seq_pos      = '0;
    seq_round    = '0;
    alt_to_seven = 1'b0;

    // Walk the directed table first
    for (int i = 0; i < DIR_ROWS; i++)
      beats.push_back(directed_tbl[i]);

    // Random beats: mostly good channels, a fair share of alternates, some rejects;
    // samples favor the extremes and repeats so ties come up often
    last_smp = '0;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      pick = $urandom_range(99);
      if (pick < 4)
        req = REQ_INVALID;
      else if (pick < 8)
        req = REQ_W'($urandom_range(10, 15));
      else if (pick < 24)
        req = REQ_ALTERNATE;
      else
        req = REQ_W'($urandom_range(0, CHANNELS - 1));
      pick = $urandom_range(9);
      if (pick == 0)
        smp = '0;
      else if (pick == 1)
        smp = '1;
      else if (pick == 2)
        smp = last_smp;
      else
        smp = SAMPLE_W'($urandom_range(0, 4095));
      last_smp = smp;
      b = '{req, smp, 1'b0, RES_NONE};
      beats.push_back(b);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every beat to go in and every expectation to drain
    while (!(send_idx == beats.size() && median_results_q.size() == 0) &&
           cycle_count < LIMIT)
      @(posedge clk);

    if (cycle_count >= LIMIT) begin
      $display("testbench: done, errors");
    end else begin
      // Give a stray late result the chance to show up
      repeat (TAIL_CYCLES) @(posedge clk);
      if (err_count == 0 && median_results_q.size() == 0)
        $display("testbench: done, clean");
      else
        $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
